// File: hdl/pareto_front_archive_unit_defines.svh
// assertion macros for the pareto front archive
`ifndef PARETO_FRONT_ARCHIVE_UNIT_DEFINES_SVH
`define PARETO_FRONT_ARCHIVE_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define PFA_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PFA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pfa_pkg.sv
// shared types, codes and the dominance test for the pareto front archive
package pfa_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int GENE_COUNT_DEF = 12;
  localparam int GENOME_W       = 12;
  localparam int OBJ_W          = 16;
  localparam int COUNT_W        = 6;
  localparam int STATUS_W       = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef struct packed {
    logic [GENOME_W-1:0] genome;
    logic [OBJ_W-1:0]    accuracy;
    logic [OBJ_W-1:0]    latency;
    logic [OBJ_W-1:0]    memory;
  } point_t;

  typedef struct packed {
    logic   valid;
    logic   mark;
    point_t pt;
  } cell_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_APPLY,
    CELL_EVEN,
    CELL_ODD,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    point_t   cand;
  } cell_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUP       = 3'd1,
    ST_DOM       = 3'd2,
    ST_FULL      = 3'd3,
    ST_IN_BUDGET = 3'd4,
    ST_FALLBACK  = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  function automatic logic dominates(point_t a, point_t b);
    logic no_worse;
    logic better;
    no_worse = (a.accuracy >= b.accuracy) && (a.latency <= b.latency) &&
               (a.memory <= b.memory);
    better   = (a.accuracy > b.accuracy) || (a.latency < b.latency) ||
               (a.memory < b.memory);
    return no_worse && better;
  endfunction

endpackage

// File: hdl/pfa_cell.sv
// one archive cell: holds a point, rotates, compacts with its neighbors
module pfa_cell import pfa_pkg::*; #(
  parameter int N     = MAX_POINTS_DEF,
  parameter int IDX   = 0,
  parameter int CNT_W = $clog2(MAX_POINTS_DEF + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic [CNT_W-1:0] count,
  input  cell_t            left,
  input  cell_t            right,
  output cell_t            q
);

  localparam logic HAS_LEFT  = (IDX > 0);
  localparam logic HAS_RIGHT = (IDX < N - 1);
  localparam logic IDX_ODD   = ((IDX % 2) == 1);

  cell_t q_next;
  logic  phase;

  always_comb begin
    q_next = q;
    phase  = (cmd.op == CELL_ODD);
    unique case (cmd.op)
      CELL_HOLD: ;
      CELL_ROTATE: q_next = right;
      CELL_APPLY: q_next.valid = q.valid & ~q.mark;
      CELL_EVEN, CELL_ODD: begin
        if (HAS_RIGHT && (IDX_ODD == phase)) begin
          if (!q.valid && right.valid) q_next = right;
        end else if (HAS_LEFT && (IDX_ODD != phase)) begin
          if (!left.valid && q.valid) q_next = left;
        end
      end
      CELL_LOAD: begin
        if (count == CNT_W'(IDX)) begin
          q_next.valid = 1'b1;
          q_next.mark  = 1'b0;
          q_next.pt    = cmd.cand;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
    q.mark <= q_next.mark;
    q.pt   <= q_next.pt;
  end

endmodule

// File: hdl/pfa_ctrl.sv
// sequencer: scan, mark, compact and append, or pick the best point
module pfa_ctrl import pfa_pkg::*; #(
  parameter int N     = MAX_POINTS_DEF,
  parameter int CNT_W = $clog2(MAX_POINTS_DEF + 1),
  parameter int IDX_W = $clog2(MAX_POINTS_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op,
  input  point_t             cand,
  input  logic [OBJ_W-1:0]   latency_budget,
  input  logic [OBJ_W-1:0]   memory_budget,
  input  cell_t              head,
  output logic               busy,
  output logic               done,
  output cell_cmd_t          cmd,
  output cell_t              feed,
  output logic [CNT_W-1:0]   count,
  output status_t            status,
  output logic [COUNT_W-1:0] point_count,
  output logic [COUNT_W-1:0] removed_count,
  output point_t             chosen
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_COMPACT, S_FINISH} state_t;

  state_t           state;
  logic [IDX_W-1:0] step;
  logic             op_r;
  point_t           cand_r;
  logic [OBJ_W-1:0] lat_b;
  logic [OBJ_W-1:0] mem_b;
  logic             rejected;
  status_t          rej_status;
  logic [CNT_W-1:0] removed;
  logic             found;
  point_t           best;
  logic             fb_seen;
  point_t           fb;

  logic last_step;
  logic cand_kills;
  logic dup_hit;
  logic dom_hit;
  logic rejected_next;
  logic has_room;

  assign busy      = (state != S_IDLE);
  assign last_step = (step == IDX_W'(N - 1));
  assign has_room  = (count < CNT_W'(N));

  always_comb begin
    cand_kills    = head.valid && dominates(cand_r, head.pt);
    dup_hit       = head.valid && (head.pt.genome == cand_r.genome);
    dom_hit       = head.valid && dominates(head.pt, cand_r);
    rejected_next = rejected || (op_r == OP_INSERT && (dup_hit || dom_hit));
    feed          = head;
    feed.mark     = cand_kills;
    cmd.cand      = cand_r;
    unique case (state)
      S_IDLE:    cmd.op = CELL_HOLD;
      S_SCAN:    cmd.op = CELL_ROTATE;
      S_APPLY:   cmd.op = CELL_APPLY;
      S_COMPACT: cmd.op = step[0] ? CELL_ODD : CELL_EVEN;
      S_FINISH:  cmd.op = (op_r == OP_INSERT && !rejected && has_room) ?
                          CELL_LOAD : CELL_HOLD;
      default:   cmd.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r       <= op;
            cand_r     <= cand;
            lat_b      <= latency_budget;
            mem_b      <= memory_budget;
            step       <= '0;
            rejected   <= 1'b0;
            rej_status <= ST_ADDED;
            removed    <= '0;
            found      <= 1'b0;
            fb_seen    <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (op_r == OP_INSERT) begin
            if (!rejected) begin
              if (dup_hit) begin
                rejected   <= 1'b1;
                rej_status <= ST_DUP;
              end else if (dom_hit) begin
                rejected   <= 1'b1;
                rej_status <= ST_DOM;
              end
            end
            if (cand_kills) removed <= removed + CNT_W'(1);
          end else if (head.valid) begin
            if (head.pt.latency <= lat_b && head.pt.memory <= mem_b &&
                (!found || head.pt.accuracy > best.accuracy)) begin
              best  <= head.pt;
              found <= 1'b1;
            end
            if (!fb_seen || head.pt.memory < fb.memory) begin
              fb      <= head.pt;
              fb_seen <= 1'b1;
            end
          end
          step <= step + IDX_W'(1);
          if (last_step) begin
            step <= '0;
            if (op_r == OP_INSERT && !rejected_next) state <= S_APPLY;
            else state <= S_FINISH;
          end
        end
        S_APPLY: begin
          count <= count - removed;
          step  <= '0;
          state <= S_COMPACT;
        end
        S_COMPACT: begin
          step <= step + IDX_W'(1);
          if (last_step) state <= S_FINISH;
        end
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (op_r == OP_INSERT) begin
            chosen <= '0;
            if (rejected) begin
              status        <= rej_status;
              removed_count <= '0;
              point_count   <= COUNT_W'(count);
            end else begin
              removed_count <= COUNT_W'(removed);
              if (has_room) begin
                status      <= ST_ADDED;
                count       <= count + CNT_W'(1);
                point_count <= COUNT_W'(count + CNT_W'(1));
              end else begin
                status      <= ST_FULL;
                point_count <= COUNT_W'(count);
              end
            end
          end else begin
            removed_count <= '0;
            point_count   <= COUNT_W'(count);
            if (found) begin
              status <= ST_IN_BUDGET;
              chosen <= best;
            end else if (fb_seen) begin
              status <= ST_FALLBACK;
              chosen <= fb;
            end else begin
              status <= ST_EMPTY;
              chosen <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/pareto_front_archive_unit.sv
// top level of the pareto front archive: cell row, sequencer and checks
//
// Points live in a row of MAX_POINTS cells, kept in insertion order from
// cell 0. Every item walks the row once by rotating it through cell 0, one
// cell per cycle. A select and a rejected insert then go to the finish
// step that raises the done strobe; an accepted insert first goes through
// an apply step that drops the points the candidate dominates and then
// odd-even neighbor swaps that close the gaps. busy is high from the cycle
// after start until the result is ready; results are registered and shown
// with done for a single cycle, and the receiver cannot stall them, so a
// new item may be started in the very cycle done is high.
module pareto_front_archive_unit import pfa_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int GENE_COUNT = GENE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [GENOME_W-1:0] genome,
  input  logic [OBJ_W-1:0]    accuracy,
  input  logic [OBJ_W-1:0]    latency,
  input  logic [OBJ_W-1:0]    memory,
  input  logic [OBJ_W-1:0]    latency_budget,
  input  logic [OBJ_W-1:0]    memory_budget,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  point_count,
  output logic [COUNT_W-1:0]  removed_count,
  output logic [GENOME_W-1:0] chosen_genome,
  output logic [OBJ_W-1:0]    chosen_accuracy,
  output logic [OBJ_W-1:0]    chosen_latency,
  output logic [OBJ_W-1:0]    chosen_memory
);

`include "pareto_front_archive_unit_defines.svh"

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [GENOME_W-1:0] GENE_MASK =
    (GENE_COUNT >= GENOME_W) ? {GENOME_W{1'b1}} : GENOME_W'((1 << GENE_COUNT) - 1);

  cell_t                 cells    [MAX_POINTS];
  cell_t                 left_in  [MAX_POINTS];
  cell_t                 right_in [MAX_POINTS];
  logic [MAX_POINTS-1:0] valid_vec;
  cell_cmd_t             cmd;
  cell_t                 feed;
  point_t                cand;
  point_t                chosen;
  status_t               status_q;
  logic [CNT_W-1:0]      count;

  always_comb begin
    cand.genome   = genome & GENE_MASK;
    cand.accuracy = accuracy;
    cand.latency  = latency;
    cand.memory   = memory;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '0;
    end else begin : g_mid
      assign left_in[i] = cells[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_last
      assign right_in[i] = feed;
    end else begin : g_inner
      assign right_in[i] = cells[i+1];
    end
    assign valid_vec[i] = cells[i].valid;

    pfa_cell #(
      .N     (MAX_POINTS),
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .count (count),
      .left  (left_in[i]),
      .right (right_in[i]),
      .q     (cells[i])
    );
  end

  pfa_ctrl #(
    .N     (MAX_POINTS),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .op             (op),
    .cand           (cand),
    .latency_budget (latency_budget),
    .memory_budget  (memory_budget),
    .head           (cells[0]),
    .busy           (busy),
    .done           (done),
    .cmd            (cmd),
    .feed           (feed),
    .count          (count),
    .status         (status_q),
    .point_count    (point_count),
    .removed_count  (removed_count),
    .chosen         (chosen)
  );

  assign status          = status_q;
  assign chosen_genome   = chosen.genome;
  assign chosen_accuracy = chosen.accuracy;
  assign chosen_latency  = chosen.latency;
  assign chosen_memory   = chosen.memory;

  `PFA_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `PFA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not start")
  `PFA_ASSERT_NOW(a_count_max, 1'b1, count <= CNT_W'(MAX_POINTS), "count above capacity")
  `PFA_ASSERT_NOW(a_valid_count, !busy, $countones(valid_vec) == count,
                  "valid cells disagree with count")

endmodule
